@@ hw/rtl/unordered_multiset_table_unit_assert.svh @@
// Assertion macros used by the RTL of the multiset table.
`ifndef UNORDERED_MULTISET_TABLE_UNIT_ASSERT_SVH
`define UNORDERED_MULTISET_TABLE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UMST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UMST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/umst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package umst_pkg;

   localparam int REQ_TYPE_W   = 2;
   localparam int ITEM_VALUE_W = 32;
   localparam int FIRST_W      = 8;
   localparam int COPY_W       = 9;
   localparam int TOTAL_W      = 9;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

endpackage

`default_nettype wire

@@ hw/rtl/umst_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface umst_req_if;
   import umst_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [ITEM_VALUE_W-1:0] item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface umst_rsp_if;
   import umst_pkg::*;

   logic               valid;
   logic               ready;
   logic               success;
   logic [FIRST_W-1:0] first_match_index;
   logic [COPY_W-1:0]  copy_count;
   logic [TOTAL_W-1:0] entry_total;
   logic               is_empty;

   modport source (output valid, output success, output first_match_index,
                   output copy_count, output entry_total, output is_empty,
                   input ready);
   modport sink   (input valid, input success, input first_match_index,
                   input copy_count, input entry_total, input is_empty,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/unordered_multiset_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fixed-capacity unordered multiset held in one on-chip RAM of CAPACITY
// entries. A request is taken only while the unit is idle, and one response
// follows each request. Add and clear go straight to the done state, which
// registers the response once the response register is free. Query scans all
// stored entries through the RAM read port, one entry per cycle. Remove scans
// until its first match, then reads the last entry and writes it into the
// matched slot; with no match it scans all stored entries. The next request
// can be accepted while a response still waits to be taken. Item values are
// truncated to ITEM_WIDTH bits, and the index and count fields of the
// response carry the low bits of their values.

module unordered_multiset_table_unit #(
   parameter int CAPACITY   = 256,
   parameter int ITEM_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   umst_req_if.sink   req_chan,
   umst_rsp_if.source rsp_chan
);

   import umst_pkg::*;

   `include "unordered_multiset_table_unit_assert.svh"

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_MOVE,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   req_kind_type          op_ff, op_in;
   logic [ITEM_WIDTH-1:0] item_ff, item_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]      copies_ff, copies_in;
   logic [IDX_W-1:0]      first_ff, first_in;
   logic                  found_ff, found_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_success_ff, rsp_success_in;
   logic [FIRST_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [COPY_W-1:0]     rsp_copies_ff, rsp_copies_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                        req_accept;
   logic [ITEM_WIDTH+ITEM_VALUE_W-1:0] item_wide;
   logic [IDX_W+FIRST_W-1:0]    first_wide;
   logic [CNT_W+COPY_W-1:0]     copies_wide;
   logic [CNT_W+TOTAL_W-1:0]    total_wide;
   logic [CNT_W-1:0]            last_cnt;
   logic                        match;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;

   umst_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && (state_ff == S_IDLE);

   assign item_wide   = {{ITEM_WIDTH{1'b0}}, req_chan.item_value};
   assign first_wide  = {{FIRST_W{1'b0}}, first_ff};
   assign copies_wide = {{COPY_W{1'b0}}, copies_ff};
   assign total_wide  = {{TOTAL_W{1'b0}}, count_ff};
   assign last_cnt    = count_ff - CNT_W'(1);
   assign match       = pend_ff && (rd_data == item_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      item_in        = item_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      copies_in      = copies_ff;
      first_in       = first_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_success_in = rsp_success_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_copies_in  = rsp_copies_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_empty_in   = rsp_empty_ff;
      wr_en          = 1'b0;
      wr_addr        = first_ff;
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in     = req_kind_type'(req_chan.req_type);
               item_in   = item_wide[ITEM_WIDTH-1:0];
               issue_in  = '0;
               copies_in = '0;
               first_in  = '0;
               found_in  = 1'b0;
               unique case (req_kind_type'(req_chan.req_type))
                  REQ_ADD: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = item_wide[ITEM_WIDTH-1:0];
                        count_in = count_ff + CNT_W'(1);
                        found_in = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  REQ_REMOVE, REQ_QUERY: begin
                     state_in = S_SCAN;
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                     found_in = 1'b1;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (match && (op_ff == REQ_REMOVE)) begin
               found_in = 1'b1;
               first_in = cmp_idx_ff;
               state_in = S_LAST;
            end else begin
               if (match) begin
                  if (copies_ff == '0) begin
                     first_in = cmp_idx_ff;
                  end
                  copies_in = copies_ff + CNT_W'(1);
                  found_in  = 1'b1;
               end
               if (issue_ff < count_ff) begin
                  rd_en      = 1'b1;
                  issue_in   = issue_ff + CNT_W'(1);
                  pend_in    = 1'b1;
                  cmp_idx_in = issue_ff[IDX_W-1:0];
               end else if (!pend_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_LAST: begin
            rd_en    = 1'b1;
            rd_addr  = last_cnt[IDX_W-1:0];
            state_in = S_MOVE;
         end
         S_MOVE: begin
            wr_en    = 1'b1;
            count_in = last_cnt;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = found_ff;
               rsp_first_in   = first_wide[FIRST_W-1:0];
               rsp_copies_in  = copies_wide[COPY_W-1:0];
               rsp_total_in   = total_wide[TOTAL_W-1:0];
               rsp_empty_in   = (count_ff == '0);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      item_ff        <= item_in;
      issue_ff       <= issue_in;
      cmp_idx_ff     <= cmp_idx_in;
      copies_ff      <= copies_in;
      first_ff       <= first_in;
      found_ff       <= found_in;
      rsp_success_ff <= rsp_success_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_copies_ff  <= rsp_copies_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.success           = rsp_success_ff;
   assign rsp_chan.first_match_index = rsp_first_ff;
   assign rsp_chan.copy_count        = rsp_copies_ff;
   assign rsp_chan.entry_total       = rsp_total_ff;
   assign rsp_chan.is_empty          = rsp_empty_ff;

   `UMST_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `UMST_ASSERT_IMPLY(a_write_place, clock, reset, wr_en,
      (state_ff == S_IDLE) || (state_ff == S_MOVE))
   `UMST_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == S_SCAN, issue_ff <= count_ff)
   `UMST_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, state_ff != S_IDLE)

endmodule

`default_nettype wire

@@ hw/rtl/umst_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module umst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ verif/multiset_response_checker.sv @@
`timescale 1ns / 1ps

module multiset_response_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   umst_req_if       req_mon,
   umst_rsp_if       rsp_mon,
   output int        mismatch_count,
   output int        pending_results
);

   import umst_pkg::*;

   typedef struct packed {
      logic               success;
      logic [FIRST_W-1:0] first_match_index;
      logic [COPY_W-1:0]  copy_count;
      logic [TOTAL_W-1:0] entry_total;
      logic               is_empty;
   } table_response_type;

   logic [ITEM_VALUE_W-1:0] model_entries [TABLE_DEPTH];
   int unsigned             model_fill = 0;
   table_response_type      predicted_responses [$];
   int                      error_tally = 0;
   int                      pending_tally = 0;

   assign mismatch_count  = error_tally;
   assign pending_results = pending_tally;

   function automatic table_response_type predict_table_response(
      input req_kind_type kind, input logic [ITEM_VALUE_W-1:0] item);
      table_response_type response;
      int unsigned        slot;
      int unsigned        copies;
      bit                 found;
      response = '0;
      copies   = 0;
      found    = 1'b0;
      case (kind)
         REQ_ADD: begin
            if (model_fill < TABLE_DEPTH) begin
               model_entries[model_fill] = item;
               model_fill++;
               response.success = 1'b1;
            end
         end
         REQ_REMOVE: begin
            for (slot = 0; slot < model_fill && !found; slot++) begin
               if (model_entries[slot] == item) begin
                  found = 1'b1;
                  response.first_match_index = slot[FIRST_W-1:0];
                  model_entries[slot] = model_entries[model_fill - 1];
                  model_fill--;
               end
            end
            response.success = found;
         end
         REQ_QUERY: begin
            for (slot = 0; slot < model_fill; slot++) begin
               if (model_entries[slot] == item) begin
                  if (copies == 0) response.first_match_index = slot[FIRST_W-1:0];
                  copies++;
               end
            end
            response.success    = (copies != 0);
            response.copy_count = copies[COPY_W-1:0];
         end
         REQ_CLEAR: begin
            model_fill       = 0;
            response.success = 1'b1;
         end
      endcase
      response.entry_total = model_fill[TOTAL_W-1:0];
      response.is_empty    = (model_fill == 0);
      return response;
   endfunction

   function automatic string describe(input table_response_type r);
      return $sformatf("success=%0d first=%0d copies=%0d total=%0d empty=%0d",
                       r.success, r.first_match_index, r.copy_count, r.entry_total,
                       r.is_empty);
   endfunction

   always @(posedge clock) begin : watch
      table_response_type observed;
      table_response_type predicted;
      if (reset) begin
         model_fill = 0;
         predicted_responses.delete();
         pending_tally <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.success           = rsp_mon.success;
            observed.first_match_index = rsp_mon.first_match_index;
            observed.copy_count        = rsp_mon.copy_count;
            observed.entry_total       = rsp_mon.entry_total;
            observed.is_empty          = rsp_mon.is_empty;
            if (predicted_responses.size() == 0) begin
               if (error_tally < 10) begin
                  $display("Response with no request outstanding: %s", describe(observed));
               end
               error_tally++;
            end else begin
               predicted = predicted_responses.pop_front();
               if (observed.success !== predicted.success
                   || observed.first_match_index !== predicted.first_match_index
                   || observed.copy_count !== predicted.copy_count
                   || observed.entry_total !== predicted.entry_total
                   || observed.is_empty !== predicted.is_empty) begin
                  if (error_tally < 10) begin
                     $display("Response mismatch at %0t: expected %s, actual %s", $realtime,
                              describe(predicted), describe(observed));
                  end
                  error_tally++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predicted_responses.push_back(predict_table_response(
               req_kind_type'(req_mon.req_type), req_mon.item_value));
         end
         pending_tally <= predicted_responses.size();
      end
   end

endmodule

@@ verif/unordered_multiset_table_unit_test.sv @@
`timescale 1ns / 1ps

module unordered_multiset_table_unit_test;
   import umst_pkg::*;

   localparam int TABLE_DEPTH    = 256;
   localparam int HALF_PERIOD_NS = 4;
   localparam int RESET_CYCLES   = 6;
   localparam int RANDOM_ITEMS   = 1450;
   localparam int SETTLE_CYCLES  = 32;
   localparam int CYCLE_LIMIT    = 2000000;
   localparam int POOL_SIZE      = 8;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    sender_valid = 1'b0;
   req_kind_type            sender_kind = REQ_CLEAR;
   logic [ITEM_VALUE_W-1:0] sender_item = '0;
   logic                    receiver_ready = 1'b0;
   int                      sender_idle_pct = 0;
   int                      receiver_idle_pct = 0;
   int                      requests_sent = 0;
   int unsigned             cycle_count = 0;
   int                      mismatch_count;
   int                      pending_results;
   logic [ITEM_VALUE_W-1:0] item_pool [POOL_SIZE];

   umst_req_if req_chan ();
   umst_rsp_if rsp_chan ();

   assign req_chan.valid      = sender_valid;
   assign req_chan.req_type   = sender_kind;
   assign req_chan.item_value = sender_item;
   assign rsp_chan.ready      = receiver_ready;

   unordered_multiset_table_unit #(
      .CAPACITY  (TABLE_DEPTH),
      .ITEM_WIDTH(ITEM_VALUE_W)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   multiset_response_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) response_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_results(pending_results)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   always @(posedge clock) begin
      receiver_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [ITEM_VALUE_W-1:0] pick_item();
      if ($urandom_range(0, 99) < 85) return item_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   task automatic send_request(input req_kind_type kind, input logic [ITEM_VALUE_W-1:0] item);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         sender_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      sender_valid <= 1'b1;
      sender_kind  <= kind;
      sender_item  <= item;
      do @(posedge clock); while (!req_chan.ready);
      requests_sent++;
   endtask

   task automatic drain_responses();
      sender_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic fill_store(input bit same_value);
      logic [ITEM_VALUE_W-1:0] common_item;
      logic [ITEM_VALUE_W-1:0] tail_item;
      common_item = pick_item();
      tail_item   = $urandom;
      send_request(REQ_CLEAR, $urandom);
      for (int slot = 0; slot < TABLE_DEPTH - 1; slot++) begin
         send_request(REQ_ADD, same_value ? common_item : pick_item());
      end
      send_request(REQ_ADD, same_value ? common_item : tail_item);
      repeat (3) send_request(REQ_ADD, pick_item());
      send_request(REQ_QUERY, common_item);
      send_request(REQ_QUERY, tail_item);
      send_request(REQ_REMOVE, tail_item);
      send_request(REQ_REMOVE, common_item);
      send_request(REQ_QUERY, common_item);
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct,
                            input bit with_fill, input bit same_value);
      int phase_end;
      int burst_len;
      int pick;
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
      phase_end         = requests_sent + RANDOM_ITEMS / 3;
      if (with_fill) fill_store(same_value);
      while (requests_sent < phase_end) begin
         burst_len = $urandom_range(10, 40);
         repeat (burst_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) send_request(REQ_ADD, pick_item());
            else if (pick < 65) send_request(REQ_REMOVE, pick_item());
            else if (pick < 95) send_request(REQ_QUERY, pick_item());
            else send_request(REQ_CLEAR, $urandom);
         end
      end
      drain_responses();
   endtask

   initial begin
      item_pool[0] = '0;
      item_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) item_pool[i] = $urandom;
      sender_idle_pct   = 21;
      receiver_idle_pct = 82;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Each request kind on an empty store, then the extreme item values,
      // duplicates, misses, a clear that keeps stale entries, and a return to empty.
      send_request(REQ_QUERY, '0);
      send_request(REQ_REMOVE, '0);
      send_request(REQ_CLEAR, $urandom);
      send_request(REQ_ADD, '0);
      send_request(REQ_ADD, '1);
      send_request(REQ_ADD, '0);
      send_request(REQ_QUERY, '0);
      send_request(REQ_QUERY, '1);
      send_request(REQ_QUERY, 32'h1234_5678);
      send_request(REQ_REMOVE, '0);
      send_request(REQ_QUERY, '0);
      send_request(REQ_REMOVE, '1);
      send_request(REQ_REMOVE, '1);
      send_request(REQ_ADD, 32'd5);
      send_request(REQ_CLEAR, $urandom);
      send_request(REQ_QUERY, 32'd5);
      send_request(REQ_ADD, 32'hA5A5_A5A5);
      send_request(REQ_QUERY, 32'hA5A5_A5A5);
      send_request(REQ_REMOVE, 32'hA5A5_A5A5);
      drain_responses();

      run_phase(21, 82, 1'b1, 1'b1);
      run_phase(82, 21, 1'b1, 1'b0);
      run_phase(0, 0, 1'b0, 1'b0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/umst_pkg.sv
hw/rtl/umst_if.sv
hw/rtl/umst_ram.sv
hw/rtl/unordered_multiset_table_unit.sv
verif/multiset_response_checker.sv
verif/unordered_multiset_table_unit_test.sv
